// ----- design/csr_pkg.sv -----
// Shared constants, types and arithmetic helpers for the complex block sampler.
`default_nettype none
package csr_pkg;

	localparam int MAX_BLOCKS  = 256;
	localparam int BLOCK_LEN   = 64;
	localparam int SAMPLE_BITS = 24;
	localparam int BLK_W       = $clog2(MAX_BLOCKS);
	localparam int SIB_W       = $clog2(BLOCK_LEN);
	localparam int ADDR_W      = BLK_W + SIB_W;
	localparam int DEPTH       = MAX_BLOCKS * BLOCK_LEN;
	localparam int WORD_W      = 2 * SAMPLE_BITS;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_RECORD = 3'd1;
	localparam logic [2:0] OP_PLAY   = 3'd2;
	localparam logic [2:0] OP_FLIP   = 3'd3;
	localparam logic [2:0] OP_SWAP   = 3'd4;

	localparam logic [2:0] REG_SIZE      = 3'd0;
	localparam logic [2:0] REG_RD_START  = 3'd1;
	localparam logic [2:0] REG_RD_END    = 3'd2;
	localparam logic [2:0] REG_MOD_START = 3'd3;
	localparam logic [2:0] REG_MOD_END   = 3'd4;
	localparam logic [2:0] REG_SPEED     = 3'd5;
	localparam logic [2:0] REG_COS       = 3'd6;
	localparam logic [2:0] REG_SIN       = 3'd7;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_TRD  = 12'b000000000010,
		ST_SW1  = 12'b000000000100,
		ST_SW2  = 12'b000000001000,
		ST_SW3  = 12'b000000010000,
		ST_SW4  = 12'b000000100000,
		ST_PAIR = 12'b000001000000,
		ST_RP   = 12'b000010000000,
		ST_RQ   = 12'b000100000000,
		ST_WP   = 12'b001000000000,
		ST_WQ   = 12'b010000000000,
		ST_FIN  = 12'b100000000000
	} state_t;

	// Floor of x/100 by a reciprocal multiply that never overshoots, then one fix-up.
	function automatic logic [8:0] div100(input logic [15:0] x);
		logic [28:0] p;
		logic [9:0]  q;
		logic [16:0] r;
		p = 29'(x) * 29'd5242;
		q = p[28:19];
		r = 17'(x) - 17'(q) * 17'd100;
		if (r >= 17'd100) begin
			q = q + 10'd1;
		end
		return q[8:0];
	endfunction

	function automatic logic [6:0] clamp_pct(input logic [6:0] p);
		return (p > 7'd100) ? 7'd100 : p;
	endfunction

	// Round half up from the Q27.14 sum of products and saturate to the sample width.
	function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input logic signed [40:0] acc);
		logic signed [41:0] t;
		logic signed [27:0] r;
		t = 42'(acc) + 42'sd8192;
		r = 28'(t >>> 14);
		if (r > 28'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (r < -28'sd8388608) begin
			return 24'sh800000;
		end
		return r[SAMPLE_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- design/csr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module csr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- design/complex_block_sampler_rotator.sv -----
// Complex block sampler: records, edits and plays back rotated sample blocks.
// A sample tick reads the store, registers the four products, then rounds into the output register.
// Start and unknown requests go straight to the result; flip and swap step each swapped
// sample through read, read, write and write states, set by the single store read port.
// After reset and after every size write a clearing pass zeroes every store word,
// during which no request is taken; the output register holds one result for the consumer.
`default_nettype none
module complex_block_sampler_rotator import csr_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// in_re, in_im, swap_first_pct, swap_second_pct, swap_len_pct, zero pad
	input  wire  [71:0] s_tdata,
	// operation
	input  wire  [2:0]  s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// out_re, out_im, record_done, play_done, command_error, zero pad
	output logic [55:0] m_tdata,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data
);

	// Configuration registers.
	logic [8:0]  size_q;
	logic [6:0]  rd_start_q, rd_end_q, mod_start_q, mod_end_q;
	logic [15:0] speed_q;
	logic [14:0] cos_q, sin_q;
	logic        cfg_we;
	logic [1:0]  settle_q;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= 9'd256;
			rd_start_q  <= 7'd0;
			rd_end_q    <= 7'd100;
			mod_start_q <= 7'd0;
			mod_end_q   <= 7'd100;
			speed_q     <= 16'd256;
			cos_q       <= 15'd16384;
			sin_q       <= 15'd0;
			settle_q    <= 2'd3;
		end else begin
			if (cfg_we) begin
				settle_q <= 2'd3;
				case (cfg_index)
					REG_SIZE:      size_q      <= cfg_data[8:0];
					REG_RD_START:  rd_start_q  <= cfg_data[6:0];
					REG_RD_END:    rd_end_q    <= cfg_data[6:0];
					REG_MOD_START: mod_start_q <= cfg_data[6:0];
					REG_MOD_END:   mod_end_q   <= cfg_data[6:0];
					REG_SPEED:     speed_q     <= cfg_data;
					REG_COS:       cos_q       <= cfg_data[14:0];
					REG_SIN:       sin_q       <= cfg_data[14:0];
					default:       ;
				endcase
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	// Derived window bounds, recomputed every cycle over two register stages.
	logic [8:0]  sz;
	logic [6:0]  rs_p, re_p, ms_p, me_p;
	logic [15:0] prod_rs_q, prod_re_q, prod_ms_q, prod_me_q;
	logic [8:0]  rs_blk_q, re_blk_q;
	logic [7:0]  ms_blk_q, me_blk_q;

	always_comb begin
		if (size_q == 9'd0) begin
			sz = 9'd1;
		end else if (size_q > 9'(MAX_BLOCKS)) begin
			sz = 9'(MAX_BLOCKS);
		end else begin
			sz = size_q;
		end
		rs_p = clamp_pct(rd_start_q);
		re_p = (clamp_pct(rd_end_q) < rs_p) ? rs_p : clamp_pct(rd_end_q);
		ms_p = clamp_pct(mod_start_q);
		me_p = (clamp_pct(mod_end_q) < ms_p) ? ms_p : clamp_pct(mod_end_q);
	end

	always_ff @(posedge clk) begin
		prod_rs_q <= 16'(rs_p) * 16'(sz);
		prod_re_q <= 16'(re_p) * 16'(sz);
		prod_ms_q <= 16'(ms_p) * 16'(sz - 9'd1);
		prod_me_q <= 16'(me_p) * 16'(sz - 9'd1);
		rs_blk_q  <= div100(prod_rs_q);
		re_blk_q  <= div100(prod_re_q);
		ms_blk_q  <= 8'(div100(prod_ms_q));
		me_blk_q  <= 8'(div100(prod_me_q));
	end

	// Input fields.
	logic [2:0]                     op;
	logic signed [SAMPLE_BITS-1:0]  in_re, in_im;
	logic [6:0]                     sw_f, sw_g, sw_l;

	assign op    = s_tuser;
	assign in_re = s_tdata[23:0];
	assign in_im = s_tdata[47:24];
	assign sw_f  = s_tdata[54:48];
	assign sw_g  = s_tdata[61:55];
	assign sw_l  = s_tdata[68:62];

	state_t state_q;
	logic   clr_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic   acc;

	assign s_tready = (state_q == ST_IDLE) && !clr_q && (settle_q == 2'd0);
	assign acc = s_tvalid && s_tready;

	// Activity state.
	logic        playing_q, recording_q;
	logic [23:0] rp_q;
	logic [8:0]  wb_q;
	logic [SIB_W-1:0] sib_q;

	// Tick decode.
	logic        tick_act, wr_tick, rd_ok, fwd, sib_last;
	logic [15:0] rd_blk;
	logic [ADDR_W-1:0] t_waddr, t_raddr;
	logic [24:0] np_sum;
	logic [23:0] np;
	logic        play_stop, rec_stop;

	always_comb begin
		tick_act = (op == OP_TICK) && (playing_q || recording_q);
		wr_tick  = recording_q && (wb_q < sz);
		rd_blk   = rp_q[23:8];
		rd_ok    = playing_q && (rd_blk < 16'(sz));
		t_waddr  = {wb_q[BLK_W-1:0], sib_q};
		t_raddr  = {rd_blk[BLK_W-1:0], sib_q};
		fwd      = wr_tick && rd_ok && (t_waddr == t_raddr);
		sib_last = (sib_q == SIB_W'(BLOCK_LEN - 1));
		np_sum   = 25'(rp_q) + 25'(speed_q);
		np       = np_sum[24] ? 24'hFFFFFF : np_sum[23:0];
		play_stop = playing_q && (np >= {7'd0, re_blk_q, 8'd0});
		rec_stop  = recording_q && ((wb_q + 9'd1) >= sz);
	end

	// Edit sequencer registers.
	logic        flip_q;
	logic [6:0]  f_q, g_q, l_q;
	logic [14:0] pa_q, pb_q;
	logic [7:0]  n_q, a_q, k_q;
	logic [9:0]  x_q, y_q;
	logic [SIB_W-1:0] idx_q;
	logic [WORD_W-1:0] tp_q;
	logic [7:0]  d_w, b_w;
	logic        pair_go, pair_skip, adv_end;
	logic        sw_err;

	always_comb begin
		d_w       = me_blk_q - ms_blk_q;
		b_w       = a_q + 8'(div100(16'(pa_q)));
		pair_go   = flip_q ? (x_q < y_q) : 1'b1;
		pair_skip = (x_q >= 10'(sz)) || (y_q >= 10'(sz));
		adv_end   = !flip_q && (k_q == 8'd0);
		sw_err    = (sw_f > sw_g) || (sw_g == 7'd0) || ((8'(sw_g) + 8'(sw_l)) > 8'd100)
		            || (sw_l > 7'd100);
	end

	// Store.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = t_waddr;
		ram_wdata = {in_im, in_re};
		ram_raddr = t_raddr;
		if (clr_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else if (acc && tick_act) begin
			ram_we = wr_tick;
		end else if (state_q == ST_RP) begin
			ram_raddr = {x_q[BLK_W-1:0], idx_q};
		end else if (state_q == ST_RQ) begin
			ram_raddr = {y_q[BLK_W-1:0], idx_q};
		end else if (state_q == ST_WP) begin
			ram_we    = 1'b1;
			ram_waddr = {x_q[BLK_W-1:0], idx_q};
			ram_wdata = ram_rdata;
		end else if (state_q == ST_WQ) begin
			ram_we    = 1'b1;
			ram_waddr = {y_q[BLK_W-1:0], idx_q};
			ram_wdata = tp_q;
		end
	end

	csr_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Tick pipeline and result registers.
	logic              zero_s1, fwd_s1;
	logic [WORD_W-1:0] wdata_s1;
	logic [WORD_W-1:0] smp;
	logic signed [SAMPLE_BITS-1:0] s_re, s_im;
	logic signed [39:0] p_rc_q, p_is_q, p_rs_q, p_ic_q;
	logic        rdone_q, pdone_q, err_q;
	logic        m_tvalid_q;
	logic [55:0] m_tdata_q;
	logic signed [SAMPLE_BITS-1:0] o_re, o_im;

	always_comb begin
		smp  = zero_s1 ? '0 : (fwd_s1 ? wdata_s1 : ram_rdata);
		s_re = smp[SAMPLE_BITS-1:0];
		s_im = smp[WORD_W-1:SAMPLE_BITS];
		o_re = round_sat(41'(p_rc_q) - 41'(p_is_q));
		o_im = round_sat(41'(p_rs_q) + 41'(p_ic_q));
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk) begin
		if (acc) begin
			zero_s1  <= !rd_ok;
			fwd_s1   <= fwd;
			wdata_s1 <= {in_im, in_re};
			f_q      <= sw_f;
			g_q      <= sw_g;
			l_q      <= sw_l;
			p_rc_q   <= '0;
			p_is_q   <= '0;
			p_rs_q   <= '0;
			p_ic_q   <= '0;
		end
		if (state_q == ST_TRD) begin
			p_rc_q <= s_re * $signed({1'b0, cos_q});
			p_is_q <= s_im * $signed({1'b0, sin_q});
			p_rs_q <= s_re * $signed({1'b0, sin_q});
			p_ic_q <= s_im * $signed({1'b0, cos_q});
		end
		if (state_q == ST_RQ) begin
			tp_q <= ram_rdata;
		end
		if (state_q == ST_SW1) begin
			pa_q <= 15'(d_w) * 15'(l_q);
			pb_q <= 15'(d_w) * 15'(f_q);
		end
		if (state_q == ST_SW2) begin
			n_q <= 8'(div100(16'(pa_q)));
			a_q <= ms_blk_q + 8'(div100(16'(pb_q)));
		end
		if (state_q == ST_SW3) begin
			pa_q <= 15'(me_blk_q - a_q) * 15'(g_q);
		end
		if ((state_q == ST_FIN) && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {5'd0, err_q, pdone_q, rdone_q, o_im, o_re};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			playing_q   <= 1'b0;
			recording_q <= 1'b0;
			rp_q        <= '0;
			wb_q        <= '0;
			sib_q       <= '0;
			m_tvalid_q  <= 1'b0;
			rdone_q     <= 1'b0;
			pdone_q     <= 1'b0;
			err_q       <= 1'b0;
			flip_q      <= 1'b0;
			x_q         <= '0;
			y_q         <= '0;
			k_q         <= '0;
			idx_q       <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (cfg_we && (cfg_index == REG_SIZE)) begin
				// A size change stops playback and recording and restarts the clearing pass.
				clr_q       <= 1'b1;
				clr_addr_q  <= '0;
				playing_q   <= 1'b0;
				recording_q <= 1'b0;
				wb_q        <= '0;
				sib_q       <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						rdone_q <= 1'b0;
						pdone_q <= 1'b0;
						err_q   <= 1'b0;
						state_q <= ST_FIN;
						case (op)
							OP_TICK: begin
								if (tick_act) begin
									state_q <= ST_TRD;
									sib_q   <= sib_q + 1'b1;
									if (sib_last) begin
										sib_q <= '0;
										if (playing_q) begin
											rp_q <= np;
											if (play_stop) begin
												playing_q <= 1'b0;
												rp_q      <= {7'd0, rs_blk_q, 8'd0};
												pdone_q   <= 1'b1;
											end
										end
										if (recording_q) begin
											wb_q <= wb_q + 9'd1;
											if (rec_stop) begin
												recording_q <= 1'b0;
												wb_q        <= '0;
												rdone_q     <= 1'b1;
											end
										end
									end
								end
							end
							OP_RECORD: begin
								if (!playing_q) begin
									sib_q <= '0;
								end
								recording_q <= 1'b1;
								wb_q        <= '0;
							end
							OP_PLAY: begin
								if (!recording_q) begin
									sib_q <= '0;
								end
								playing_q <= 1'b1;
								rp_q      <= {7'd0, rs_blk_q, 8'd0};
							end
							OP_FLIP: begin
								flip_q  <= 1'b1;
								x_q     <= 10'(ms_blk_q);
								y_q     <= 10'(me_blk_q);
								state_q <= ST_PAIR;
							end
							OP_SWAP: begin
								flip_q <= 1'b0;
								if (sw_err) begin
									err_q <= 1'b1;
								end else begin
									state_q <= ST_SW1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_TRD: state_q <= ST_FIN;
				ST_SW1: state_q <= ST_SW2;
				ST_SW2: state_q <= ST_SW3;
				ST_SW3: state_q <= ST_SW4;
				ST_SW4: begin
					x_q     <= 10'(a_q) + 10'(n_q);
					y_q     <= 10'(b_w) + 10'(n_q);
					k_q     <= n_q;
					state_q <= ST_PAIR;
				end
				ST_PAIR: begin
					if (!pair_go) begin
						state_q <= ST_FIN;
					end else if (pair_skip) begin
						if (adv_end) begin
							state_q <= ST_FIN;
						end else if (flip_q) begin
							x_q <= x_q + 10'd1;
							y_q <= y_q - 10'd1;
						end else begin
							k_q <= k_q - 8'd1;
							x_q <= x_q - 10'd1;
							y_q <= y_q - 10'd1;
						end
					end else begin
						idx_q   <= '0;
						state_q <= ST_RP;
					end
				end
				ST_RP: state_q <= ST_RQ;
				ST_RQ: state_q <= ST_WP;
				ST_WP: state_q <= ST_WQ;
				ST_WQ: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= ST_RP;
					if (idx_q == SIB_W'(BLOCK_LEN - 1)) begin
						idx_q   <= '0;
						state_q <= ST_PAIR;
						if (adv_end) begin
							state_q <= ST_FIN;
						end else if (flip_q) begin
							x_q <= x_q + 10'd1;
							y_q <= y_q - 10'd1;
						end else begin
							k_q <= k_q - 8'd1;
							x_q <= x_q - 10'd1;
							y_q <= y_q - 10'd1;
						end
					end
				end
				ST_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The clearing pass and new requests never overlap.
	assert property (@(posedge clk) disable iff (!arst_n) clr_q |-> !s_tready)
		else $error("request taken during clearing pass");

	// Requests are only taken by an idle sequencer.
	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> (state_q == ST_IDLE))
		else $error("ready raised while busy");

	// Outside the clearing pass the store is written only by a tick or a flip or swap write step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && !clr_q) |-> ((acc && tick_act) || (state_q == ST_WP) || (state_q == ST_WQ)))
		else $error("unexpected store write");

	// A finished request always lands in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && (!m_tvalid_q || m_tready)) |=> (m_tvalid_q && (state_q == ST_IDLE)))
		else $error("result not delivered");

endmodule
`default_nettype wire
